// ===== rtl/core/istk_pkg.sv =====
`timescale 1ns / 1ps

package istk_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int IDX_W       = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int ACT_W       = 3;
    localparam int FAULT_W     = 3;
    localparam int S_TDATA_W   = ((ACT_W + DATA_W + 7) / 8) * 8;
    localparam int M_TDATA_W   = ((DATA_W + 7) / 8) * 8;
    localparam int M_TUSER_W   = FAULT_W;

    typedef enum logic [ACT_W-1:0] {
        ACT_PUSH = 3'd0,
        ACT_DUMP = 3'd1,
        ACT_PEEK = 3'd2,
        ACT_POP  = 3'd3,
        ACT_ADD  = 3'd4
    } action_t;

    typedef enum logic [FAULT_W-1:0] {
        FAULT_NONE = 3'd0,
        FAULT_FULL = 3'd1,
        FAULT_PEEK = 3'd2,
        FAULT_POP  = 3'd3,
        FAULT_ADD  = 3'd4
    } fault_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_WAIT,
        ST_ADD_WAIT,
        ST_OUT
    } state_t;

endpackage

// ===== rtl/core/integer_stack_push_pop_add_core.sv =====
`timescale 1ns / 1ps

// Channel  | Dir | Handshake          | Payload
// s_       | in  | s_tvalid, s_tready | s_tdata: action, operand
// m_       | out | m_tvalid, m_tready | m_tdata: item_value; m_tuser: fault; m_tlast: last_of_run
//
// Push, pop and faulting operations are handled in idle; a fault result then waits in the
// output register until taken. Peek goes through ST_RD_WAIT to the result in ST_OUT, and add
// through ST_RD_WAIT and ST_ADD_WAIT: each stack read goes through the single registered read port of the stack memory.
// Dump gives one result per element, each read through ST_RD_WAIT and offered in ST_OUT.
// Reset (aresetn low, synchronous) empties the stack; the memory itself is not cleared.
// s_tready is low while an operation is in progress or a result waits on m_tready.

module integer_stack_push_pop_add_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [istk_pkg::S_TDATA_W-1:0]      s_tdata,   // [2:0] action, [34:3] operand
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [istk_pkg::M_TDATA_W-1:0]      m_tdata,   // [31:0] item_value
    output logic [istk_pkg::M_TUSER_W-1:0]      m_tuser,   // [2:0] fault
    output logic                                m_tlast
);

    localparam int IDX_W  = istk_pkg::IDX_W;
    localparam int CNT_W  = istk_pkg::CNT_W;
    localparam int DATA_W = istk_pkg::DATA_W;
    localparam int ACT_W  = istk_pkg::ACT_W;

    istk_pkg::state_t  state_reg, state_next;
    istk_pkg::action_t op_reg, op_next;
    istk_pkg::fault_t  out_fault_reg, out_fault_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  ptr_reg, ptr_next;
    logic [DATA_W-1:0] top_reg, top_next;
    logic [DATA_W-1:0] out_value_reg, out_value_next;
    logic              out_last_reg, out_last_next;

    logic [DATA_W-1:0] mem [istk_pkg::STACK_DEPTH];
    logic [DATA_W-1:0] rd_data_reg;
    logic              mem_we, mem_re;
    logic [IDX_W-1:0]  mem_waddr, mem_raddr;
    logic [DATA_W-1:0] mem_wdata;

    logic [ACT_W-1:0]  in_action;
    logic [DATA_W-1:0] in_operand;
    logic              in_fire;
    logic [CNT_W-1:0]  count_m1, count_m2;
    logic              is_full;

    assign in_action  = s_tdata[ACT_W-1:0];
    assign in_operand = s_tdata[ACT_W+DATA_W-1:ACT_W];
    assign s_tready   = (state_reg == istk_pkg::ST_IDLE);
    assign in_fire    = s_tvalid && s_tready;
    assign count_m1   = count_reg - CNT_W'(1);
    assign count_m2   = count_reg - CNT_W'(2);
    assign is_full    = (count_reg == CNT_W'(istk_pkg::STACK_DEPTH));

    assign m_tvalid = (state_reg == istk_pkg::ST_OUT);
    assign m_tdata  = istk_pkg::M_TDATA_W'(out_value_reg);
    assign m_tuser  = out_fault_reg;
    assign m_tlast  = out_last_reg;

    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        top_next       = top_reg;
        out_value_next = out_value_reg;
        out_fault_next = out_fault_reg;
        out_last_next  = out_last_reg;
        mem_we         = 1'b0;
        mem_waddr      = count_reg[IDX_W-1:0];
        mem_wdata      = in_operand;
        mem_re         = 1'b0;
        mem_raddr      = count_m1[IDX_W-1:0];

        case (state_reg)
            istk_pkg::ST_IDLE: begin
                if (in_fire) begin
                    out_value_next = '0;
                    out_last_next  = 1'b1;
                    case (in_action)
                        istk_pkg::ACT_PUSH: begin
                            if (is_full) begin
                                out_fault_next = istk_pkg::FAULT_FULL;
                                state_next     = istk_pkg::ST_OUT;
                            end else begin
                                mem_we     = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        istk_pkg::ACT_DUMP: begin
                            if (count_reg != '0) begin
                                op_next    = istk_pkg::ACT_DUMP;
                                ptr_next   = count_m1[IDX_W-1:0];
                                mem_re     = 1'b1;
                                state_next = istk_pkg::ST_RD_WAIT;
                            end
                        end
                        istk_pkg::ACT_PEEK: begin
                            if (count_reg == '0) begin
                                out_fault_next = istk_pkg::FAULT_PEEK;
                                state_next     = istk_pkg::ST_OUT;
                            end else begin
                                op_next    = istk_pkg::ACT_PEEK;
                                mem_re     = 1'b1;
                                state_next = istk_pkg::ST_RD_WAIT;
                            end
                        end
                        istk_pkg::ACT_POP: begin
                            if (count_reg == '0) begin
                                out_fault_next = istk_pkg::FAULT_POP;
                                state_next     = istk_pkg::ST_OUT;
                            end else begin
                                count_next = count_m1;
                            end
                        end
                        istk_pkg::ACT_ADD: begin
                            if (count_reg < CNT_W'(2)) begin
                                out_fault_next = istk_pkg::FAULT_ADD;
                                state_next     = istk_pkg::ST_OUT;
                            end else begin
                                op_next    = istk_pkg::ACT_ADD;
                                mem_re     = 1'b1;
                                state_next = istk_pkg::ST_RD_WAIT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            istk_pkg::ST_RD_WAIT: begin
                if (op_reg == istk_pkg::ACT_ADD) begin
                    top_next   = rd_data_reg;
                    mem_re     = 1'b1;
                    mem_raddr  = count_m2[IDX_W-1:0];
                    state_next = istk_pkg::ST_ADD_WAIT;
                end else begin
                    out_value_next = rd_data_reg;
                    out_fault_next = istk_pkg::FAULT_NONE;
                    out_last_next  = (op_reg != istk_pkg::ACT_DUMP) || (ptr_reg == '0);
                    state_next     = istk_pkg::ST_OUT;
                end
            end
            istk_pkg::ST_ADD_WAIT: begin
                mem_we     = 1'b1;
                mem_waddr  = count_m2[IDX_W-1:0];
                mem_wdata  = rd_data_reg + top_reg;
                count_next = count_m1;
                state_next = istk_pkg::ST_IDLE;
            end
            istk_pkg::ST_OUT: begin
                if (m_tready) begin
                    if (!out_last_reg) begin
                        ptr_next   = ptr_reg - IDX_W'(1);
                        mem_re     = 1'b1;
                        mem_raddr  = ptr_reg - IDX_W'(1);
                        state_next = istk_pkg::ST_RD_WAIT;
                    end else begin
                        state_next = istk_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = istk_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= istk_pkg::ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        ptr_reg       <= ptr_next;
        top_reg       <= top_next;
        out_value_reg <= out_value_next;
        out_fault_reg <= out_fault_next;
        out_last_reg  <= out_last_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input accepted while a result is pending");

    a_fault_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser != istk_pkg::FAULT_NONE)) |-> (m_tlast && (m_tdata == '0)))
        else $error("fault result not final or not zero");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(istk_pkg::STACK_DEPTH))
        else $error("element count beyond stack depth");

    a_push_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && (in_action == istk_pkg::ACT_PUSH) && !is_full)
        |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("push did not advance element count");

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    localparam int DATA_W      = istk_pkg::DATA_W;
    localparam int FAULT_W     = istk_pkg::FAULT_W;
    localparam int ACT_W       = istk_pkg::ACT_W;
    localparam int STACK_DEPTH = istk_pkg::STACK_DEPTH;
    localparam int S_TDATA_W   = istk_pkg::S_TDATA_W;
    localparam int M_TDATA_W   = istk_pkg::M_TDATA_W;
    localparam int M_TUSER_W   = istk_pkg::M_TUSER_W;

    localparam int RANDOM_OPS     = 286;
    localparam int HOLD_OFF_LEN   = 300;
    localparam int HOLD_AT_OP     = 140;
    localparam int DRAIN_AT_OP    = 220;
    localparam int SETTLE_CYCLES  = 20;
    localparam int WATCHDOG_LIMIT = 2000;

    localparam int MODE_FILL     = 0;
    localparam int MODE_DRAIN    = 1;
    localparam int MODE_MIXED    = 2;
    localparam int MODE_SATURATE = 3;

    typedef struct {
        logic [DATA_W-1:0]  value;
        logic [FAULT_W-1:0] fault;
        logic               last;
    } stack_result_t;

    class stack_tracker;
        logic [DATA_W-1:0] entries[STACK_DEPTH];
        int                depth_now;
        int                deepest;
        stack_result_t     awaited[$];
        int                errors;
        int                checked;
        int                op_seen[8];
        int                fault_seen[5];

        function new();
            depth_now = 0;
            deepest   = 0;
            errors    = 0;
            checked   = 0;
            foreach (op_seen[i]) op_seen[i] = 0;
            foreach (fault_seen[i]) fault_seen[i] = 0;
        endfunction

        function void expect_result(logic [DATA_W-1:0] value, istk_pkg::fault_t fault,
                                    logic last);
            stack_result_t r;
            r.value = value;
            r.fault = fault;
            r.last  = last;
            awaited.push_back(r);
            fault_seen[fault]++;
        endfunction

        function void note_op(logic [ACT_W-1:0] act, logic [DATA_W-1:0] opnd);
            op_seen[act]++;
            case (act)
                istk_pkg::ACT_PUSH: begin
                    if (depth_now >= STACK_DEPTH) begin
                        expect_result('0, istk_pkg::FAULT_FULL, 1'b1);
                    end else begin
                        entries[depth_now] = opnd;
                        depth_now++;
                        if (depth_now > deepest) deepest = depth_now;
                    end
                end
                istk_pkg::ACT_DUMP: begin
                    for (int k = 0; k < depth_now; k++) begin
                        expect_result(entries[depth_now - 1 - k], istk_pkg::FAULT_NONE,
                                      (k == depth_now - 1));
                    end
                end
                istk_pkg::ACT_PEEK: begin
                    if (depth_now == 0) begin
                        expect_result('0, istk_pkg::FAULT_PEEK, 1'b1);
                    end else begin
                        expect_result(entries[depth_now - 1], istk_pkg::FAULT_NONE, 1'b1);
                    end
                end
                istk_pkg::ACT_POP: begin
                    if (depth_now == 0) expect_result('0, istk_pkg::FAULT_POP, 1'b1);
                    else depth_now--;
                end
                istk_pkg::ACT_ADD: begin
                    if (depth_now < 2) begin
                        expect_result('0, istk_pkg::FAULT_ADD, 1'b1);
                    end else begin
                        entries[depth_now - 2] = entries[depth_now - 2] + entries[depth_now - 1];
                        depth_now--;
                    end
                end
                default: begin
                end
            endcase
        endfunction

        function void check_result(logic [DATA_W-1:0] value, logic [FAULT_W-1:0] fault,
                                   logic last);
            stack_result_t exp_r;
            checked++;
            if (awaited.size() == 0) begin
                $error("unexpected result: item_value %0h fault %0d last_of_run %0d",
                       value, fault, last);
                errors++;
                return;
            end
            exp_r = awaited.pop_front();
            if (value !== exp_r.value) begin
                $error("item_value: expected %0h, actual %0h", exp_r.value, value);
                errors++;
            end
            if (fault !== exp_r.fault) begin
                $error("fault: expected %0d, actual %0d", exp_r.fault, fault);
                errors++;
            end
            if (last !== exp_r.last) begin
                $error("last_of_run: expected %0d, actual %0d", exp_r.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 m_tlast;

    stack_tracker tracker;
    bit           hold_go;
    int           stall_cycles;

    integer_stack_push_pop_add_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                tracker.check_result(m_tdata[DATA_W-1:0], m_tuser, m_tlast);
            end
            if (s_tvalid && s_tready) begin
                tracker.note_op(s_tdata[ACT_W-1:0], s_tdata[ACT_W+DATA_W-1:ACT_W]);
            end
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // output side: random stall patterns, plus one long hold-off on request
    initial begin
        int hold_left;
        int pattern_left;
        int pattern_mode;
        int phase;
        bit hold_done;
        hold_left    = 0;
        pattern_left = 0;
        pattern_mode = 0;
        phase        = 0;
        hold_done    = 1'b0;
        m_tready     = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_go && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_OFF_LEN;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                if (pattern_left == 0) begin
                    pattern_mode = $urandom_range(0, 3);
                    pattern_left = $urandom_range(10, 80);
                end
                pattern_left--;
                phase++;
                case (pattern_mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= (phase % 3 != 0);
                endcase
            end
        end
    end

    task automatic send_op(input logic [ACT_W-1:0] act, input logic [DATA_W-1:0] opnd);
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - ACT_W - DATA_W){1'b0}}, opnd, act};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic idle_for(input int cycles);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        repeat (cycles - 1) @(negedge aclk);
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (tracker.awaited.size() != 0) @(negedge aclk);
    endtask

    function automatic logic [ACT_W-1:0] pick_action(int mode);
        int r;
        if ($urandom_range(0, 99) < 4) return ACT_W'($urandom_range(5, 7));
        r = $urandom_range(0, 99);
        case (mode)
            MODE_SATURATE: begin
                return (r < 92) ? istk_pkg::ACT_PUSH : ACT_W'($urandom_range(1, 4));
            end
            MODE_FILL: begin
                if (r < 70) return istk_pkg::ACT_PUSH;
                if (r < 78) return istk_pkg::ACT_DUMP;
                if (r < 86) return istk_pkg::ACT_PEEK;
                if (r < 93) return istk_pkg::ACT_POP;
                return istk_pkg::ACT_ADD;
            end
            MODE_DRAIN: begin
                if (r < 15) return istk_pkg::ACT_PUSH;
                if (r < 20) return istk_pkg::ACT_DUMP;
                if (r < 30) return istk_pkg::ACT_PEEK;
                if (r < 65) return istk_pkg::ACT_POP;
                return istk_pkg::ACT_ADD;
            end
            MODE_MIXED: begin
                if (r < 35) return istk_pkg::ACT_PUSH;
                if (r < 47) return istk_pkg::ACT_DUMP;
                if (r < 60) return istk_pkg::ACT_PEEK;
                if (r < 80) return istk_pkg::ACT_POP;
                return istk_pkg::ACT_ADD;
            end
            default: begin
                return istk_pkg::ACT_PUSH;
            end
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'hFFFF_FFFF;
            3: return DATA_W'($urandom_range(0, 3));
            default: return $urandom();
        endcase
    endfunction

    initial begin
        int ops_done;
        int seg_left;
        int seg_mode;
        int burst_left;
        bit drained_once;
        logic [ACT_W-1:0] act;

        tracker      = new();
        hold_go      = 1'b0;
        stall_cycles = 0;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_op(istk_pkg::ACT_PEEK, 32'h0);
        send_op(istk_pkg::ACT_POP,  32'hFFFF_FFFF);
        send_op(istk_pkg::ACT_ADD,  32'h0);
        send_op(istk_pkg::ACT_DUMP, 32'h0);
        send_op(ACT_W'(5), 32'hFFFF_FFFF);
        send_op(ACT_W'(7), 32'h0);
        send_op(istk_pkg::ACT_PUSH, 32'h7FFF_FFFF);
        send_op(istk_pkg::ACT_ADD,  32'h0);
        send_op(istk_pkg::ACT_PUSH, 32'h0000_0001);
        send_op(istk_pkg::ACT_ADD,  32'h0);
        send_op(istk_pkg::ACT_PEEK, 32'h0);
        send_op(istk_pkg::ACT_PUSH, 32'h8000_0000);
        send_op(istk_pkg::ACT_ADD,  32'h0);
        send_op(istk_pkg::ACT_PEEK, 32'h0);
        send_op(istk_pkg::ACT_PUSH, 32'hFFFF_FFFF);
        send_op(istk_pkg::ACT_PUSH, 32'h0000_0000);
        send_op(istk_pkg::ACT_PUSH, 32'hA5A5_5A5A);
        send_op(ACT_W'(6), 32'h1234_5678);
        send_op(istk_pkg::ACT_DUMP, 32'h0);
        send_op(istk_pkg::ACT_POP,  32'h0);
        send_op(istk_pkg::ACT_POP,  32'h0);
        send_op(istk_pkg::ACT_POP,  32'h0);
        send_op(istk_pkg::ACT_POP,  32'h0);
        send_op(istk_pkg::ACT_PEEK, 32'h0);

        ops_done     = 0;
        seg_mode     = MODE_SATURATE;
        seg_left     = 45;
        burst_left   = $urandom_range(1, 24);
        drained_once = 1'b0;
        while (ops_done < RANDOM_OPS) begin
            if (seg_left == 0) begin
                seg_mode = $urandom_range(0, 3);
                seg_left = $urandom_range(20, 70);
            end
            if (burst_left == 0) begin
                if ($urandom_range(0, 3) != 0) idle_for($urandom_range(1, 8));
                burst_left = $urandom_range(1, 24);
            end
            if (ops_done >= HOLD_AT_OP) hold_go = 1'b1;
            if (ops_done >= DRAIN_AT_OP && !drained_once) begin
                drained_once = 1'b1;
                wait_drained();
            end
            act = pick_action(seg_mode);
            send_op(act, pick_operand());
            if (act <= istk_pkg::ACT_ADD) begin
                ops_done++;
                seg_left--;
            end
            burst_left--;
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (tracker.awaited.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Ran push %0d dump %0d peek %0d pop %0d add %0d undefined %0d, peak depth %0d",
                 tracker.op_seen[istk_pkg::ACT_PUSH], tracker.op_seen[istk_pkg::ACT_DUMP],
                 tracker.op_seen[istk_pkg::ACT_PEEK], tracker.op_seen[istk_pkg::ACT_POP],
                 tracker.op_seen[istk_pkg::ACT_ADD],
                 tracker.op_seen[5] + tracker.op_seen[6] + tracker.op_seen[7],
                 tracker.deepest);
        $display("Checked %0d results; faults full %0d, peek %0d, pop %0d, add %0d",
                 tracker.checked, tracker.fault_seen[istk_pkg::FAULT_FULL],
                 tracker.fault_seen[istk_pkg::FAULT_PEEK],
                 tracker.fault_seen[istk_pkg::FAULT_POP],
                 tracker.fault_seen[istk_pkg::FAULT_ADD]);
        if (tracker.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== integer_stack_push_pop_add_core.f =====
rtl/core/istk_pkg.sv
rtl/core/integer_stack_push_pop_add_core.sv
tb/sv/tb_top.sv
